[hw/rtl/sha1_message_digest_unit_defines.svh]
// Assertion helpers shared by the digest unit's RTL files.
`ifndef SHA1_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define SHA1MD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1md check failed");

// Next-cycle implication, off while reset is held.
`define SHA1MD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1md check failed");

`endif

[hw/rtl/sha1md_pkg.sv]
package sha1md_pkg;

  localparam int unsigned ROUNDS    = 80;
  localparam int unsigned WIN_WORDS = 16;
  localparam int unsigned CV_WORDS  = 5;
  localparam int unsigned CNT_W     = 61;   // byte count; bit length is this times 8

  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [2:0]  LAST_IDX  = 3'd4;
  localparam logic [5:0]  LAST_POS  = 6'd63;

  localparam logic [31:0] INIT_CHAIN [CV_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_BYTE_LAST,
    KIND_LAST_ONLY
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // Queue side: valid item at push or at the head
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  // Where the engine goes once a compression has been folded in
  typedef enum logic [1:0] {
    AFTER_IDLE,
    AFTER_PAD,
    AFTER_LEN,
    AFTER_OUT
  } after_t;

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    priority if (t < 7'd20) f = (b & c) | (~b & d);
    else if (t < 7'd40)     f = b ^ c ^ d;
    else if (t < 7'd60)     f = (b & c) | (b & d) | (c & d);
    else                    f = b ^ c ^ d;
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    priority if (t < 7'd20) k = K_0;
    else if (t < 7'd40)     k = K_1;
    else if (t < 7'd60)     k = K_2;
    else                    k = K_3;
    return k;
  endfunction

endpackage

[hw/rtl/sha1md_if.sv]
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                  output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

[hw/rtl/sha1md_front.sv]
module sha1md_front import sha1md_pkg::*; (
  sha1md_in_if.sink in_ch,
  input  logic      q_full,
  output q_t        q_push
);

  logic accept;

  // Take a transaction whenever the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Classify; drop an item that carries neither a byte nor the end mark
  always_comb begin
    q_push.valid     = accept && (in_ch.has_byte || in_ch.last_byte);
    q_push.item.data = in_ch.data_byte;
    priority if (in_ch.has_byte && in_ch.last_byte) q_push.item.kind = KIND_BYTE_LAST;
    else if (in_ch.has_byte)                        q_push.item.kind = KIND_BYTE;
    else                                            q_push.item.kind = KIND_LAST_ONLY;
  end

endmodule

[hw/rtl/sha1md_fifo.sv]
`include "sha1_message_digest_unit_defines.svh"

module sha1md_fifo import sha1md_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  q_t   push,
  output logic full,
  output q_t   head,
  input  logic pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  `SHA1MD_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push.valid, count_r < CNT_W'(DEPTH))
  `SHA1MD_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, pop, count_r != '0)

endmodule

[hw/rtl/sha1md_core.sv]
`include "sha1_message_digest_unit_defines.svh"

module sha1md_core import sha1md_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  q_t           head,
  output logic         pop,
  sha1md_out_if.source out_ch
);

  state_t              state_r, state_nxt;
  after_t              after_r, after_nxt;
  logic [31:0]         chain_r [CV_WORDS];
  logic [31:0]         chain_nxt [CV_WORDS];
  logic [31:0]         rr_r [CV_WORDS];
  logic [31:0]         rr_nxt [CV_WORDS];
  logic [31:0]         win_r [WIN_WORDS];
  logic [31:0]         win_nxt [WIN_WORDS];
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [6:0]          round_r, round_nxt;
  logic [2:0]          idx_r, idx_nxt;

  logic                out_valid_r;
  logic [31:0]         out_word_r;
  logic [2:0]          out_idx_r;
  logic                out_last_r;

  logic                out_load;
  logic                byte_wr;
  logic [5:0]          pos;
  logic                pad_spills;
  logic [63:0]         len_bits;
  logic [31:0]         sched_x;
  logic [31:0]         w_t;
  logic [31:0]         round_sum;

  assign pos        = cnt_r[5:0];
  assign pad_spills = (pos[5:3] == 3'b111);  // no room left for the length
  assign len_bits   = {cnt_r, 3'b000};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          unique case (head.item.kind)
            KIND_BYTE:      if (pos == LAST_POS) state_nxt = S_ROUND;
            KIND_BYTE_LAST: state_nxt = (pos == LAST_POS) ? S_ROUND : S_PAD;
            KIND_LAST_ONLY: state_nxt = S_PAD;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_PAD:   state_nxt = S_ROUND;
      S_LEN:   state_nxt = S_ROUND;
      S_ROUND: if (round_r == LAST_ROUND) state_nxt = S_ADD;
      S_ADD: begin
        unique case (after_r)
          AFTER_IDLE: state_nxt = S_IDLE;
          AFTER_PAD:  state_nxt = S_PAD;
          AFTER_LEN:  state_nxt = S_LEN;
          AFTER_OUT:  state_nxt = S_OUT;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_OUT:   if (out_load && idx_r == LAST_IDX) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = (state_r == S_IDLE) && head.valid;
    byte_wr   = pop && (head.item.kind != KIND_LAST_ONLY);
    out_load  = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
    after_nxt = after_r;
    unique case (state_r)
      S_IDLE:  if (pop) after_nxt = (head.item.kind == KIND_BYTE_LAST) ? AFTER_PAD
                                                                       : AFTER_IDLE;
      S_PAD:   after_nxt = pad_spills ? AFTER_LEN : AFTER_OUT;
      S_LEN:   after_nxt = AFTER_OUT;
      default: after_nxt = after_r;
    endcase
  end

  // One round: schedule word and five-operand sum
  always_comb begin
    sched_x   = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    w_t       = (round_r < 7'd16) ? win_r[0] : {sched_x[30:0], sched_x[31]};
    round_sum = {rr_r[0][26:0], rr_r[0][31:27]}
              + round_f(round_r, rr_r[1], rr_r[2], rr_r[3])
              + rr_r[4] + w_t + round_k(round_r);
  end

  // Datapath
  always_comb begin
    chain_nxt = chain_r;
    rr_nxt    = rr_r;
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    round_nxt = round_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        // Drop the byte into its big-endian lane
        if (byte_wr) begin
          win_nxt[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = head.item.data;
          cnt_nxt = cnt_r + 1'b1;
          if (pos == LAST_POS) begin
            rr_nxt    = chain_r;
            round_nxt = '0;
          end
        end
      end
      S_PAD: begin
        // Pad byte at the fill level, zeros after it
        for (int i = 0; i < WIN_WORDS; i++) begin
          if (4'(i) == pos[5:2]) begin
            for (int j = 0; j < 4; j++) begin
              if (2'(j) == pos[1:0]) begin
                win_nxt[i][8*(3-j) +: 8] = PAD_BYTE;
              end else if (2'(j) > pos[1:0]) begin
                win_nxt[i][8*(3-j) +: 8] = 8'h00;
              end
            end
          end else if (4'(i) > pos[5:2]) begin
            win_nxt[i] = '0;
          end
        end
        if (!pad_spills) begin
          win_nxt[14] = len_bits[63:32];
          win_nxt[15] = len_bits[31:0];
        end
        rr_nxt    = chain_r;
        round_nxt = '0;
      end
      S_LEN: begin
        for (int i = 0; i < WIN_WORDS; i++) begin
          win_nxt[i] = '0;
        end
        win_nxt[14] = len_bits[63:32];
        win_nxt[15] = len_bits[31:0];
        rr_nxt      = chain_r;
        round_nxt   = '0;
      end
      S_ROUND: begin
        // Roll the window and the working words
        for (int i = 0; i < WIN_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_WORDS-1] = w_t;
        rr_nxt[0] = round_sum;
        rr_nxt[1] = rr_r[0];
        rr_nxt[2] = {rr_r[1][1:0], rr_r[1][31:2]};
        rr_nxt[3] = rr_r[2];
        rr_nxt[4] = rr_r[3];
        round_nxt = round_r + 1'b1;
      end
      S_ADD: begin
        for (int i = 0; i < CV_WORDS; i++) begin
          chain_nxt[i] = chain_r[i] + rr_r[i];
        end
      end
      S_OUT: begin
        // Hand out one word; restart the message after the fifth
        if (out_load) begin
          if (idx_r == LAST_IDX) begin
            idx_nxt   = '0;
            chain_nxt = INIT_CHAIN;
            cnt_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        chain_nxt = chain_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= AFTER_IDLE;
      chain_r     <= INIT_CHAIN;
      cnt_r       <= '0;
      round_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      after_r  <= after_nxt;
      chain_r  <= chain_nxt;
      cnt_r    <= cnt_nxt;
      round_r  <= round_nxt;
      idx_r    <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    rr_r  <= rr_nxt;
    if (out_load) begin
      out_word_r <= chain_r[idx_r];
      out_idx_r  <= idx_r;
      out_last_r <= (idx_r == LAST_IDX);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = out_last_r;

  `SHA1MD_ASSERT_NOW(a_round_in_range, clk, rst_n, state_r == S_ROUND, round_r <= LAST_ROUND)
  `SHA1MD_ASSERT_NOW(a_pop_only_idle, clk, rst_n, pop, state_r == S_IDLE)
  `SHA1MD_ASSERT_NOW(a_out_rises_from_out, clk, rst_n, $rose(out_valid_r),
                     $past(state_r) == S_OUT)
  `SHA1MD_ASSERT_NOW(a_last_word_matches, clk, rst_n, out_valid_r,
                     out_last_r == (out_idx_r == LAST_IDX))

endmodule

[hw/rtl/sha1_message_digest_unit.sv]
// Input: one byte transaction per cycle into a small queue while it has room; the engine
// absorbs a queued byte per cycle while idle and compresses each full 64-byte block (80
// rounds in one shared round unit, then the chaining add) before taking more bytes.
// Last item: padding fills one or two blocks, then five digest words leave one per cycle
// from the output register while ready is high. Synchronous active-low reset empties the
// queue, loads the initial chaining value and clears the length count; no clearing pass.
module sha1_message_digest_unit import sha1md_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  sha1md_in_if.sink    in_ch,
  sha1md_out_if.source out_ch
);

  q_t   q_push;
  q_t   q_head;
  logic q_full;
  logic q_pop;

  sha1md_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  sha1md_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  sha1md_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule
